// ===== hdl/wist_pkg.sv =====
// ----------------------------------------------------------------------------
// wist_pkg
// Shared types and constants for the weighted index sum tree: request and
// response payloads, field widths and request codes.
// ----------------------------------------------------------------------------
package wist_pkg;

	// Default number of tree entries
	localparam int unsigned ENTRIES_DEF = 256;

	// Field widths
	localparam int unsigned IDX_FIELD_W = 8;
	localparam int unsigned WEIGHT_W    = 24;
	localparam int unsigned SUM_W       = 32;

	// Request codes
	localparam logic REQ_SET  = 1'b0;
	localparam logic REQ_FIND = 1'b1;

	// Request payload
	typedef struct packed {
		logic                   req_type;
		logic [IDX_FIELD_W-1:0] entry_index;
		logic [WEIGHT_W-1:0]    new_weight;
		logic [SUM_W-1:0]       position;
	} wist_req_t;

	// Response payload
	typedef struct packed {
		logic [IDX_FIELD_W-1:0] found_index;
		logic                   miss;
		logic [SUM_W-1:0]       total_weight;
	} wist_rsp_t;

endpackage

// ===== hdl/wist_store.sv =====
// ----------------------------------------------------------------------------
// wist_store
// Node storage for the sum tree: one weight memory (one read, one write port)
// and one subtree-sum memory (two read ports, one write port). Reads are
// registered.
// ----------------------------------------------------------------------------
module wist_store import wist_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
	input  logic                clk,
	// weight memory
	input  logic [IDX_W-1:0]    w_raddr,
	output logic [WEIGHT_W-1:0] w_rdata,
	input  logic                w_we,
	input  logic [IDX_W-1:0]    w_waddr,
	input  logic [WEIGHT_W-1:0] w_wdata,
	// subtree-sum memory
	input  logic [IDX_W-1:0]    s_raddr_a,
	output logic [SUM_W-1:0]    s_rdata_a,
	input  logic [IDX_W-1:0]    s_raddr_b,
	output logic [SUM_W-1:0]    s_rdata_b,
	input  logic                s_we,
	input  logic [IDX_W-1:0]    s_waddr,
	input  logic [SUM_W-1:0]    s_wdata
);

	logic [WEIGHT_W-1:0] weight_mem [ENTRIES];
	logic [SUM_W-1:0]    sum_mem    [ENTRIES];

	// Weight memory: write and registered read
	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= w_wdata;
		end
		w_rdata <= weight_mem[w_raddr];
	end

	// Sum memory: write and two registered reads
	always_ff @(posedge clk) begin
		if (s_we) begin
			sum_mem[s_waddr] <= s_wdata;
		end
		s_rdata_a <= sum_mem[s_raddr_a];
		s_rdata_b <= sum_mem[s_raddr_b];
	end

endmodule

// ===== hdl/weighted_index_sum_tree.sv =====
// Operation: set walks up from the entry to the root, one sum update per level,
//   then registers the result; find walks down from the root one tree level at
//   a time. A find at or above the total and a set beyond the last entry go
//   straight to the output register. A full output register adds its wait.
//   Throughput: one transaction at a time; the next is taken once the result is
//   registered. Reset: a clearing pass zeroes both memories first.
// ----------------------------------------------------------------------------
// weighted_index_sum_tree
// Implicit binary heap of Q16.8 weights with per-node subtree sums. Set
// requests walk up the path adding the weight change; find requests walk
// down from the root to the entry whose weight band holds the position.
// ----------------------------------------------------------------------------
module weighted_index_sum_tree import wist_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  wist_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output wist_rsp_t out_data
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned CH_W  = $clog2(2 * ENTRIES + 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SET_RD,
		S_SET_DELTA,
		S_SET_UP,
		S_F_RD,
		S_F_EVAL,
		S_F_STEER,
		S_RESP
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       clr_q;
	logic [IDX_W-1:0]       node_q;
	logic [WEIGHT_W-1:0]    wnew_q;
	logic [SUM_W-1:0]       delta_q;
	logic [SUM_W-1:0]       pos_q;
	logic [SUM_W-1:0]       total_q;
	logic [IDX_FIELD_W-1:0] found_q;
	logic                   miss_q;
	logic                   out_valid_q;
	wist_rsp_t              out_q;

	// Memory ports
	logic [IDX_W-1:0]    w_raddr;
	logic [WEIGHT_W-1:0] w_rdata;
	logic                w_we;
	logic [IDX_W-1:0]    w_waddr;
	logic [WEIGHT_W-1:0] w_wdata;
	logic [IDX_W-1:0]    s_raddr_a;
	logic [SUM_W-1:0]    s_rdata_a;
	logic [IDX_W-1:0]    s_raddr_b;
	logic [SUM_W-1:0]    s_rdata_b;
	logic                s_we;
	logic [IDX_W-1:0]    s_waddr;
	logic [SUM_W-1:0]    s_wdata;

	// Tree navigation
	logic [CH_W-1:0]  left_c;
	logic [CH_W-1:0]  right_c;
	logic             left_ok;
	logic             right_ok;
	logic [IDX_W-1:0] parent_c;
	logic [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] lsum;
	logic [SUM_W-1:0] pos_right;
	logic             idx_in_range;

	// Compute children, parent and updated sum of the current node
	assign left_c    = (CH_W'(node_q) << 1) + CH_W'(1);
	assign right_c   = (CH_W'(node_q) << 1) + CH_W'(2);
	assign left_ok   = left_c < CH_W'(ENTRIES);
	assign right_ok  = right_c < CH_W'(ENTRIES);
	assign parent_c  = (node_q - IDX_W'(1)) >> 1;
	assign sum_new   = s_rdata_a + delta_q;
	assign lsum      = left_ok ? s_rdata_a : '0;
	assign pos_right = pos_q - lsum;

	assign idx_in_range = 32'(in_data.entry_index) < 32'(ENTRIES);

	// Select memory read addresses
	always_comb begin
		w_raddr   = node_q;
		s_raddr_a = IDX_W'(left_c);
		s_raddr_b = IDX_W'(right_c);
		unique case (state_q)
			S_SET_DELTA: begin
				s_raddr_a = node_q;
			end
			S_SET_UP: begin
				s_raddr_a = parent_c;
			end
			default: begin
			end
		endcase
	end

	// Select memory writes: clearing pass, weight store, path update
	always_comb begin
		w_we    = (state_q == S_CLEAR) || (state_q == S_SET_DELTA);
		w_waddr = (state_q == S_CLEAR) ? clr_q : node_q;
		w_wdata = (state_q == S_CLEAR) ? '0 : wnew_q;
		s_we    = (state_q == S_CLEAR) || (state_q == S_SET_UP);
		s_waddr = (state_q == S_CLEAR) ? clr_q : node_q;
		s_wdata = (state_q == S_CLEAR) ? '0 : sum_new;
	end

	wist_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk      (clk),
		.w_raddr  (w_raddr),
		.w_rdata  (w_rdata),
		.w_we     (w_we),
		.w_waddr  (w_waddr),
		.w_wdata  (w_wdata),
		.s_raddr_a(s_raddr_a),
		.s_rdata_a(s_rdata_a),
		.s_raddr_b(s_raddr_b),
		.s_rdata_b(s_rdata_b),
		.s_we     (s_we),
		.s_waddr  (s_waddr),
		.s_wdata  (s_wdata)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			node_q      <= '0;
			wnew_q      <= '0;
			delta_q     <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			found_q     <= '0;
			miss_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// drop the result once it is accepted, unless a new result is being registered
			if (out_valid_q && out_ready && (state_q != S_RESP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						wnew_q <= in_data.new_weight;
						pos_q  <= in_data.position;
						if (in_data.req_type == REQ_SET) begin
							found_q <= in_data.entry_index;
							miss_q  <= 1'b0;
							node_q  <= IDX_W'(in_data.entry_index);
							state_q <= idx_in_range ? S_SET_RD : S_RESP;
						end else if (in_data.position >= total_q) begin
							found_q <= '0;
							miss_q  <= 1'b1;
							state_q <= S_RESP;
						end else begin
							node_q  <= '0;
							state_q <= S_F_RD;
						end
					end
				end
				S_SET_RD: begin
					state_q <= S_SET_DELTA;
				end
				S_SET_DELTA: begin
					delta_q <= SUM_W'(wnew_q) - SUM_W'(w_rdata);
					state_q <= S_SET_UP;
				end
				S_SET_UP: begin
					// advance to the parent until the root is updated
					if (node_q == '0) begin
						total_q <= sum_new;
						state_q <= S_RESP;
					end else begin
						node_q <= parent_c;
					end
				end
				S_F_RD: begin
					state_q <= S_F_EVAL;
				end
				S_F_EVAL: begin
					if (pos_q < SUM_W'(w_rdata)) begin
						found_q <= IDX_FIELD_W'(node_q);
						miss_q  <= 1'b0;
						state_q <= S_RESP;
					end else begin
						pos_q   <= pos_q - SUM_W'(w_rdata);
						state_q <= S_F_STEER;
					end
				end
				S_F_STEER: begin
					if (pos_q < lsum) begin
						node_q  <= IDX_W'(left_c);
						state_q <= S_F_RD;
					end else if (!right_ok || pos_right >= s_rdata_b) begin
						found_q <= '0;
						miss_q  <= 1'b1;
						state_q <= S_RESP;
					end else begin
						pos_q   <= pos_right;
						node_q  <= IDX_W'(right_c);
						state_q <= S_F_RD;
					end
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.found_index  <= found_q;
						out_q.miss         <= miss_q;
						out_q.total_weight <= total_q;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
